### hw/rtl/multilevel_ready_queue_macros.svh
// ----------------------------------------------------------------------------
// Multilevel ready queue assertion macros
// Shared macros for the concurrent assertions of the ready queue RTL.
// ----------------------------------------------------------------------------
`ifndef MULTILEVEL_READY_QUEUE_MACROS_SVH
`define MULTILEVEL_READY_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MRQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MRQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/mrq_pkg.sv
// ----------------------------------------------------------------------------
// Multilevel ready queue package
// Sizes, codes and sequencer states shared by the ready queue RTL.
// ----------------------------------------------------------------------------
`default_nettype none

package mrq_pkg;

   // Sizing of the queue.
   localparam int MAX_THREADS = 64;
   localparam int NUM_BUCKETS = 4;
   localparam int TICK_BITS   = 32;

   localparam int ID_W    = $clog2(MAX_THREADS);
   localparam int BKT_W   = $clog2(NUM_BUCKETS);
   localparam int CNT_W   = $clog2(MAX_THREADS + 1);
   localparam int THR_W   = 16;
   localparam int DATA_W  = 32;
   localparam int ADDR_W  = 3;
   localparam int FUNC_W  = 2;
   localparam int STAT_W  = 2;

   // First id that is out of range, one bit wider than an id.
   localparam logic [ID_W:0] THREAD_LIMIT = (ID_W + 1)'(MAX_THREADS);

   // Bucket that every id uses in single-queue mode.
   localparam logic [BKT_W-1:0] DEFAULT_BUCKET = BKT_W'(2);

   // Reset value of the starvation threshold.
   localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(100);

   // Register index, taken from the word address bit of the bus.
   localparam logic REG_SINGLE_MODE = 1'b0;
   localparam logic REG_STARVATION  = 1'b1;

   typedef enum logic [FUNC_W-1:0] {
      FN_ENQUEUE = 2'd0,
      FN_DEQUEUE = 2'd1,
      FN_REMOVE  = 2'd2,
      FN_TICK    = 2'd3
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 2'd0,
      ST_DUPLICATE = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_NOT_QUEUED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SQ_IDLE,
      SQ_LOOKUP,
      SQ_EXEC
   } state_type;

endpackage

`default_nettype wire

### hw/rtl/multilevel_ready_queue.sv
// Flow: the idle state takes a request, the lookup state reads its links
// and the exec state modifies, writes back and registers the result,
// holding while the response is stalled. Requests are taken only in idle.
// Reset: synchronous; it clears the queued flags, bucket state, time
// counter and registers. The link memories need no clearing pass.
// ----------------------------------------------------------------------------
// Multilevel ready queue
// Four FIFO buckets of thread ids with per-thread links held in memories,
// priority dequeue with starvation aging, remove from anywhere, time ticks.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multilevel_ready_queue_macros.svh"

module multilevel_ready_queue (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // Request channel.
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [mrq_pkg::FUNC_W-1:0]    req_func,
   input  wire logic [mrq_pkg::ID_W-1:0]      req_thread_id,
   input  wire logic [mrq_pkg::BKT_W-1:0]     req_bucket,
   // Response channel.
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [mrq_pkg::STAT_W-1:0]         rsp_status,
   output logic [mrq_pkg::ID_W-1:0]           rsp_chosen_thread,
   output logic [mrq_pkg::CNT_W-1:0]          rsp_ready_count,
   // Register port.
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [mrq_pkg::ADDR_W-1:0]    csr_paddr,
   input  wire logic [mrq_pkg::DATA_W-1:0]    csr_pwdata,
   output logic [mrq_pkg::DATA_W-1:0]         csr_prdata,
   output logic                               csr_pready
);

   import mrq_pkg::*;

   // ------------------------------------------------------------------
   // Declarations
   // ------------------------------------------------------------------
   state_type               state_ff, state_in;

   func_type                item_func_ff;
   logic [ID_W-1:0]         item_id_ff;
   logic [BKT_W-1:0]        item_bucket_ff;

   logic [BKT_W-1:0]        pick_ff, pick_in;
   logic                    pick_ok_ff, pick_ok_in;
   logic [ID_W-1:0]         addr_ff, addr_in;

   logic [ID_W-1:0]         rd_next_ff;
   logic [ID_W-1:0]         rd_prev_ff;
   logic [BKT_W-1:0]        rd_bucket_ff;

   logic [ID_W-1:0]         next_mem   [MAX_THREADS];
   logic [ID_W-1:0]         prev_mem   [MAX_THREADS];
   logic [BKT_W-1:0]        bucket_mem [MAX_THREADS];

   logic [ID_W-1:0]         head_ff   [NUM_BUCKETS];
   logic [ID_W-1:0]         head_in   [NUM_BUCKETS];
   logic [ID_W-1:0]         tail_ff   [NUM_BUCKETS];
   logic [ID_W-1:0]         tail_in   [NUM_BUCKETS];
   logic [NUM_BUCKETS-1:0]  empty_ff, empty_in;
   logic [TICK_BITS-1:0]    served_ff [NUM_BUCKETS];
   logic [TICK_BITS-1:0]    served_in [NUM_BUCKETS];
   logic [TICK_BITS-1:0]    tick_ff, tick_in;
   logic [CNT_W-1:0]        total_ff, total_in;
   logic [MAX_THREADS-1:0]  queued_ff;

   logic                    single_mode_ff;
   logic [THR_W-1:0]        threshold_ff;

   logic                    rsp_valid_ff;
   logic [STAT_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]         rsp_chosen_ff, rsp_chosen_in;
   logic [CNT_W-1:0]        rsp_count_ff;

   logic                    req_take;
   logic                    out_free;
   logic                    exec_fire;
   logic                    id_ok;
   logic                    csr_write;

   logic [NUM_BUCKETS-1:0]  aged;

   logic                    next_we;
   logic [ID_W-1:0]         next_wa, next_wd;
   logic                    prev_we;
   logic [ID_W-1:0]         prev_wa, prev_wd;
   logic                    bkt_we;
   logic [BKT_W-1:0]        bkt_wd;
   logic                    q_set, q_clr;

   logic                    unlink_go;
   logic [BKT_W-1:0]        enq_b;
   logic [BKT_W-1:0]        unl_b;
   logic                    is_head, is_tail;

   // ------------------------------------------------------------------
   // Handshake terms
   // ------------------------------------------------------------------
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign exec_fire = (state_ff == SQ_EXEC) && out_free;
   assign id_ok     = ({1'b0, addr_ff} < THREAD_LIMIT);

   // ------------------------------------------------------------------
   // Sequencer: accept, look up the links, then modify and write back.
   // Only one item is in flight, so a write always lands before the next
   // item reads the link memories and no forwarding is needed.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      case (state_ff)
         SQ_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = SQ_LOOKUP;
            end
         end
         SQ_LOOKUP: begin
            state_in = SQ_EXEC;
         end
         SQ_EXEC: begin
            if (out_free) begin
               state_in = SQ_IDLE;
            end
         end
         default: begin
            state_in = SQ_IDLE;
         end
      endcase
   end

   // Capture the request fields on a transfer.
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_func_ff   <= func_type'(req_func);
         item_id_ff     <= req_thread_id;
         item_bucket_ff <= req_bucket;
      end
   end

   // ------------------------------------------------------------------
   // Dequeue choice, not single mode: lowest starving, else highest busy.
   // ------------------------------------------------------------------
   always_comb begin
      aged = '0;
      for (int b = 0; b < NUM_BUCKETS - 1; b++) begin
         aged[b] = !empty_ff[b] &&
                   ((tick_ff - served_ff[b]) >= TICK_BITS'(threshold_ff));
      end
   end

   always_comb begin
      pick_in    = '0;
      pick_ok_in = 1'b0;
      if (single_mode_ff) begin
         pick_in    = DEFAULT_BUCKET;
         pick_ok_in = !empty_ff[DEFAULT_BUCKET];
      end else begin
         for (int b = 0; b < NUM_BUCKETS; b++) begin
            if (!empty_ff[b]) begin
               pick_in    = BKT_W'(b);
               pick_ok_in = 1'b1;
            end
         end
         for (int b = NUM_BUCKETS - 2; b >= 0; b--) begin
            if (aged[b]) begin
               pick_in    = BKT_W'(b);
               pick_ok_in = 1'b1;
            end
         end
      end
      if (item_func_ff == FN_DEQUEUE) begin
         addr_in = head_ff[pick_in];
      end else begin
         addr_in = item_id_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == SQ_LOOKUP) begin
         pick_ff    <= pick_in;
         pick_ok_ff <= pick_ok_in;
         addr_ff    <= addr_in;
      end
   end

   // ------------------------------------------------------------------
   // Link memories: read in the lookup cycle, written in the exec cycle.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (state_ff == SQ_LOOKUP) begin
         rd_next_ff   <= next_mem[addr_in];
         rd_prev_ff   <= prev_mem[addr_in];
         rd_bucket_ff <= bucket_mem[addr_in];
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire && next_we) begin
         next_mem[next_wa] <= next_wd;
      end
      if (exec_fire && prev_we) begin
         prev_mem[prev_wa] <= prev_wd;
      end
      if (exec_fire && bkt_we) begin
         bucket_mem[addr_ff] <= bkt_wd;
      end
   end

   // ------------------------------------------------------------------
   // Modify: work out the memory writes and the new bucket state.
   // ------------------------------------------------------------------
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      empty_in      = empty_ff;
      served_in     = served_ff;
      tick_in       = tick_ff;
      total_in      = total_ff;
      next_we       = 1'b0;
      next_wa       = addr_ff;
      next_wd       = addr_ff;
      prev_we       = 1'b0;
      prev_wa       = addr_ff;
      prev_wd       = addr_ff;
      bkt_we        = 1'b0;
      q_set         = 1'b0;
      q_clr         = 1'b0;
      unlink_go     = 1'b0;
      rsp_status_in = ST_OK;
      rsp_chosen_in = '0;
      enq_b         = single_mode_ff ? DEFAULT_BUCKET : item_bucket_ff;
      bkt_wd        = enq_b;
      unl_b         = rd_bucket_ff;
      is_head       = (head_ff[unl_b] == addr_ff);
      is_tail       = (tail_ff[unl_b] == addr_ff);

      case (item_func_ff)
         FN_ENQUEUE: begin
            if (!id_ok) begin
               rsp_status_in = ST_NOT_QUEUED;
            end else if (queued_ff[addr_ff]) begin
               rsp_status_in = ST_DUPLICATE;
            end else begin
               // Append at the tail; an empty bucket takes the id as head.
               if (empty_ff[enq_b]) begin
                  head_in[enq_b] = addr_ff;
               end else begin
                  next_we = 1'b1;
                  next_wa = tail_ff[enq_b];
                  next_wd = addr_ff;
                  prev_we = 1'b1;
                  prev_wa = addr_ff;
                  prev_wd = tail_ff[enq_b];
               end
               tail_in[enq_b]  = addr_ff;
               empty_in[enq_b] = 1'b0;
               bkt_we          = 1'b1;
               q_set           = 1'b1;
               total_in        = total_ff + CNT_W'(1);
            end
         end
         FN_DEQUEUE: begin
            if (!pick_ok_ff) begin
               rsp_status_in = ST_EMPTY;
            end else begin
               unlink_go          = 1'b1;
               rsp_chosen_in      = addr_ff;
               served_in[pick_ff] = tick_ff;
            end
         end
         FN_REMOVE: begin
            if (!id_ok || !queued_ff[addr_ff]) begin
               rsp_status_in = ST_NOT_QUEUED;
            end else begin
               unlink_go = 1'b1;
            end
         end
         FN_TICK: begin
            tick_in = tick_ff + TICK_BITS'(1);
         end
         default: begin
            rsp_status_in = ST_OK;
         end
      endcase

      // Unlink from the bucket recorded for the id when it was queued.
      if (unlink_go) begin
         if (is_head && is_tail) begin
            empty_in[unl_b] = 1'b1;
         end else if (is_head) begin
            head_in[unl_b] = rd_next_ff;
         end else if (is_tail) begin
            tail_in[unl_b] = rd_prev_ff;
         end else begin
            next_we = 1'b1;
            next_wa = rd_prev_ff;
            next_wd = rd_next_ff;
            prev_we = 1'b1;
            prev_wa = rd_next_ff;
            prev_wd = rd_prev_ff;
         end
         q_clr = 1'b1;
         if (total_ff != '0) begin
            total_in = total_ff - CNT_W'(1);
         end
      end
   end

   // ------------------------------------------------------------------
   // Write back the bucket state and the queued flags.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         empty_ff  <= '1;
         tick_ff   <= '0;
         total_ff  <= '0;
         queued_ff <= '0;
         for (int b = 0; b < NUM_BUCKETS; b++) begin
            served_ff[b] <= '0;
         end
      end else if (exec_fire) begin
         empty_ff  <= empty_in;
         tick_ff   <= tick_in;
         total_ff  <= total_in;
         served_ff <= served_in;
         if (q_set) begin
            queued_ff[addr_ff] <= 1'b1;
         end
         if (q_clr) begin
            queued_ff[addr_ff] <= 1'b0;
         end
      end
   end

   // Head and tail pointers carry no reset; their values are used only once written.
   always_ff @(posedge clock) begin
      if (exec_fire) begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   // ------------------------------------------------------------------
   // Response register, loaded as the item finishes.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         rsp_status_ff <= rsp_status_in;
         rsp_chosen_ff <= rsp_chosen_in;
         rsp_count_ff  <= total_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_chosen_thread = rsp_chosen_ff;
   assign rsp_ready_count   = rsp_count_ff;

   // ------------------------------------------------------------------
   // Register port.
   // ------------------------------------------------------------------
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         single_mode_ff <= 1'b0;
         threshold_ff   <= THRESHOLD_RESET;
      end else if (csr_write) begin
         if (csr_paddr[2] == REG_SINGLE_MODE) begin
            single_mode_ff <= csr_pwdata[0];
         end else begin
            threshold_ff <= csr_pwdata[THR_W-1:0];
         end
      end
   end

   always_comb begin
      if (csr_paddr[2] == REG_STARVATION) begin
         csr_prdata = DATA_W'(threshold_ff);
      end else begin
         csr_prdata = DATA_W'(single_mode_ff);
      end
   end

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `MRQ_ASSERT_SAME(a_count_matches_flags, clock, reset, 1'b1,
      total_ff == CNT_W'($countones(queued_ff)), "queued count disagrees with flags")
   `MRQ_ASSERT_SAME(a_all_empty_no_count, clock, reset, &empty_ff,
      total_ff == '0, "all buckets empty but ids counted as queued")
   `MRQ_ASSERT_SAME(a_dequeue_queued, clock, reset,
      exec_fire && item_func_ff == FN_DEQUEUE && pick_ok_ff,
      queued_ff[addr_ff], "dequeue hands out an id that is not queued")
   `MRQ_ASSERT_NEXT(a_enqueue_sets_flag, clock, reset,
      exec_fire && item_func_ff == FN_ENQUEUE && rsp_status_in == ST_OK,
      queued_ff[$past(addr_ff)], "enqueued id not marked as queued")

endmodule

`default_nettype wire
